// ===== rtl/lgs_pkg.sv =====
// Shared constants and types for the Life generation stencil core.
// No dependencies; used by the core.
`default_nettype none

package lgs_pkg;

	localparam int MAX_SIDE   = 1024;
	localparam int LINE_DEPTH = MAX_SIDE + 2;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int SIDE_W     = 11;
	localparam int RESET_SIDE = 8;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef logic [SIDE_W-1:0] side_t;
	typedef logic [ADDR_W-1:0] coord_t;
	// bit 1: cell two rows up, bit 0: cell one row up
	typedef logic [1:0] line_word_t;
	// bits 2..0: column one left (top, middle, bottom), bits 5..3: two left
	typedef logic [5:0] window_t;

	function automatic logic [1:0] pop3(input logic [2:0] v);
		pop3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lgs_if.sv =====
// Stream channels of the Life stencil core: padded cells in, next states out.
// Depends on nothing; valid/ready handshake, a beat moves on valid && ready.
`default_nettype none

interface lgs_cell_if;
	logic valid;
	logic ready;
	logic cell_in;

	modport source (output valid, output cell_in, input ready);
	modport sink   (input valid, input cell_in, output ready);
endinterface

interface lgs_result_if;
	logic valid;
	logic ready;
	logic next_cell;
	logic last_of_generation;

	modport source (output valid, output next_cell, output last_of_generation, input ready);
	modport sink   (input valid, input next_cell, input last_of_generation, output ready);
endinterface

`default_nettype wire

// ===== rtl/life_generation_stencil_core.sv =====
// Life B3/S23 generation stencil over a streamed padded board.
// A cell beat that completes a result passes stage 1, then the result is held in the output register.
// Throughput: one cell beat per cycle; the line memory takes one read and one write each
// cycle, and a held result beat stalls the input.
// Reset: positions, window and side (8) reset at once; line memory needs no clear,
// since every entry is rewritten in the first two rows before it is used.
// Depends on lgs_pkg and the channel interfaces in lgs_if.sv.
`default_nettype none

module life_generation_stencil_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire lgs_pkg::side_t cfg_wr_data,
	lgs_cell_if.sink           cells,
	lgs_result_if.source       results
);
	import lgs_pkg::*;

	line_word_t line_mem [LINE_DEPTH];

	coord_t     side_last_q;
	coord_t     row_q;
	coord_t     col_q;
	window_t    window_q;

	logic       valid_s1;
	logic       emit_s1;
	logic       last_s1;
	logic       cell_s1;
	coord_t     addr_s1;
	line_word_t rd_data_s1;

	logic       out_valid_q;
	logic       out_next_q;
	logic       out_last_q;

	logic       in_accept;
	logic       out_free;
	logic       advance1;
	logic [2:0] newcol;
	logic [3:0] count;
	logic       next_state;
	side_t      side_eff;
	logic       col_end;
	logic       row_end;

	// stage 1 frees up when its result (if any) can enter the output register
	assign out_free     = !out_valid_q || results.ready;
	assign advance1     = valid_s1 && (!emit_s1 || out_free);
	assign cells.ready  = !valid_s1 || advance1;
	assign in_accept    = cells.valid && cells.ready;

	assign results.valid              = out_valid_q;
	assign results.next_cell          = out_next_q;
	assign results.last_of_generation = out_last_q;

	assign col_end = (col_q == side_last_q);
	assign row_end = (row_q == side_last_q);

	always_comb begin
		if (cfg_wr_data == '0) begin
			side_eff = side_t'(1);
		end else if (cfg_wr_data > side_t'(MAX_SIDE)) begin
			side_eff = side_t'(MAX_SIDE);
		end else begin
			side_eff = cfg_wr_data;
		end
	end

	always_comb begin
		newcol     = {rd_data_s1[1], rd_data_s1[0], cell_s1};
		count      = {2'b00, pop3(window_q[5:3])} + {2'b00, pop3(newcol)}
		           + {3'b000, window_q[0]} + {3'b000, window_q[2]};
		next_state = (count == BIRTH_COUNT) || (window_q[1] && (count == SURVIVE_COUNT));
	end

	// side register and raster position of the next incoming cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_last_q <= coord_t'(RESET_SIDE + 1);
			row_q       <= '0;
			col_q       <= '0;
		end else if (cfg_wr_en) begin
			side_last_q <= coord_t'(side_eff) + coord_t'(1);
			row_q       <= '0;
			col_q       <= '0;
		end else if (in_accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + coord_t'(1);
			end else begin
				col_q <= col_q + coord_t'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
			emit_s1  <= (row_q >= coord_t'(2)) && (col_q >= coord_t'(2));
			last_s1  <= row_end && col_end;
		end else if (advance1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cell_s1 <= cells.cell_in;
			addr_s1 <= col_q;
		end
	end

	// line memory: read on accept, write back the shifted column in stage 1
	always_ff @(posedge clk) begin
		if (advance1) begin
			line_mem[addr_s1] <= {rd_data_s1[0], cell_s1};
		end
		if (in_accept) begin
			rd_data_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (advance1) begin
			window_q <= {window_q[2:0], newcol};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance1 && emit_s1) begin
			out_next_q <= next_state;
			out_last_q <= last_s1;
		end
	end

`ifndef ASSERT_OFF
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= side_last_q && row_q <= side_last_q)
		else $error("raster position beyond board");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && advance1 |-> col_q != addr_s1)
		else $error("line memory read and write hit the same entry");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |-> emit_s1)
		else $error("end of generation flagged on a non-interior cell");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance1 |-> !cells.ready)
		else $error("input taken while stage 1 is stalled");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> row_q == '0 && col_q == '0)
		else $error("side write did not restart the generation");
`endif

endmodule

`default_nettype wire
